### hw/rtl/tai_pkg.sv
// ----------------------------------------------------------------------------
// Tile animation index table: shared definitions
// Field widths, item codes, animation modes, controller states and the
// random-number step used by the table controller.
// ----------------------------------------------------------------------------
package tai_pkg;

	localparam int unsigned TILE_COUNT_DEF = 2048;

	localparam int FIELD_W = 11;
	localparam int OP_W    = 2;
	localparam int MODE_W  = 2;
	localparam int LFSR_W  = 16;

	localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;
	localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;

	// Item opcodes
	localparam logic [OP_W-1:0] OP_ANIMATE = 2'd0;
	localparam logic [OP_W-1:0] OP_READ    = 2'd1;
	localparam logic [OP_W-1:0] OP_WRITE   = 2'd2;

	// Animation modes
	localparam logic [MODE_W-1:0] MODE_FWD  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_BWD  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_RAND = 2'd2;
	localparam logic [MODE_W-1:0] MODE_PING = 2'd3;

	// Fields reduced modulo the table size
	localparam int WRAP_FIELDS = 4;
	localparam int F_FIRST     = 0;
	localparam int F_LAST      = 1;
	localparam int F_ENTRY     = 2;
	localparam int F_VALUE     = 3;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WRAP,
		ST_ANIM,
		ST_RAND_STEP,
		ST_RAND_DIV,
		ST_RAND_WR,
		ST_READ,
		ST_RDATA,
		ST_WRITE,
		ST_RESP
	} state_t;

	// One Galois step: shift right, fold in the taps when a one drops out
	function automatic logic [LFSR_W-1:0] lfsr_next(input logic [LFSR_W-1:0] s);
		logic [LFSR_W-1:0] n;
		n = s >> 1;
		if (s[0]) begin
			n = n ^ LFSR_TAPS;
		end
		return n;
	endfunction

endpackage

### hw/rtl/tai_if.sv
// ----------------------------------------------------------------------------
// Tile animation index table: channel interfaces
// Command channel (animate, read, write items) and response channel, each
// with valid/ready handshake and payload.
// ----------------------------------------------------------------------------
interface tai_cmd_if;
	import tai_pkg::*;

	logic               valid;
	logic               ready;
	logic [OP_W-1:0]    opcode;
	logic [FIELD_W-1:0] first_tile;
	logic [FIELD_W-1:0] last_tile;
	logic [MODE_W-1:0]  anim_mode;
	logic [FIELD_W-1:0] entry;
	logic [FIELD_W-1:0] entry_value;

	modport source (
		output valid, opcode, first_tile, last_tile, anim_mode, entry, entry_value,
		input  ready
	);

	modport sink (
		input  valid, opcode, first_tile, last_tile, anim_mode, entry, entry_value,
		output ready
	);
endinterface

interface tai_rsp_if;
	import tai_pkg::*;

	logic               valid;
	logic               ready;
	logic [FIELD_W-1:0] read_value;
	logic               read_reverse;

	modport source (
		output valid, read_value, read_reverse,
		input  ready
	);

	modport sink (
		input  valid, read_value, read_reverse,
		output ready
	);
endinterface

### hw/rtl/tai_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module tai_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

### hw/rtl/tai_wrap.sv
// ----------------------------------------------------------------------------
// Tile animation index table: field reduction
// Reduces the tile fields of an item modulo the table size in a two-stage
// pipeline: reciprocal multiply for the quotient, then multiply back and one
// correcting subtract.
// ----------------------------------------------------------------------------
module tai_wrap #(
	parameter int unsigned TILE_COUNT = tai_pkg::TILE_COUNT_DEF,
	parameter int          AW         = $clog2(TILE_COUNT)
) (
	input  logic                                                  clk,
	input  logic                                                  arst_n,
	input  logic                                                  in_valid,
	input  logic [tai_pkg::WRAP_FIELDS-1:0][tai_pkg::FIELD_W-1:0] in_fields,
	output logic                                                  out_valid,
	output logic [tai_pkg::WRAP_FIELDS-1:0][AW-1:0]               out_fields
);
	import tai_pkg::*;

	localparam int RECIP_SHIFT = 24;
	localparam int RW          = RECIP_SHIFT + 1;
	localparam int PW          = FIELD_W + RW;
	localparam int CW          = $clog2(TILE_COUNT + 1);
	localparam int MW          = FIELD_W + CW;

	// Rounded down, so the quotient is low by at most one for 11-bit values
	localparam logic [RW-1:0] RECIP = RW'((64'd1 << RECIP_SHIFT) / TILE_COUNT);
	localparam logic [MW-1:0] C_EXT = MW'(TILE_COUNT);

	logic                                  vld_s1, vld_s2;
	logic [WRAP_FIELDS-1:0][FIELD_W-1:0]   v_s1, v_s2;
	logic [WRAP_FIELDS-1:0][FIELD_W-1:0]   q_s1;
	logic [WRAP_FIELDS-1:0][MW-1:0]        p_s2;
	logic [WRAP_FIELDS-1:0][PW-1:0]        prod;
	logic [WRAP_FIELDS-1:0][MW-1:0]        rem;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
		end
	end

	always_comb begin
		for (int i = 0; i < WRAP_FIELDS; i++) begin
			prod[i] = PW'(in_fields[i]) * PW'(RECIP);
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < WRAP_FIELDS; i++) begin
			v_s1[i] <= in_fields[i];
			q_s1[i] <= prod[i][RECIP_SHIFT +: FIELD_W];
			v_s2[i] <= v_s1[i];
			p_s2[i] <= MW'(q_s1[i]) * C_EXT;
		end
	end

	always_comb begin
		for (int i = 0; i < WRAP_FIELDS; i++) begin
			rem[i] = MW'(v_s2[i]) - p_s2[i];
			if (rem[i] >= C_EXT) begin
				out_fields[i] = AW'(rem[i] - C_EXT);
			end else begin
				out_fields[i] = AW'(rem[i]);
			end
		end
	end

	assign out_valid = vld_s2;

endmodule

### hw/rtl/tile_animation_index_table_top.sv
// ----------------------------------------------------------------------------
// Tile animation index table
// Per-tile animated tile numbers and reverse flags, advanced over a tile
// range by animate items and inspected or loaded by read and write items.
// ----------------------------------------------------------------------------
// After reset the block sweeps both tables back to identity values and
// clear flags, one entry per cycle, and takes no item until the sweep is
// done. Items are handled one at a time; every item returns exactly one
// response item, zero except for a read. Each item first has its tile
// fields reduced modulo the table size. A read then passes the READ and
// RDATA states and a write the WRITE state before the response register
// is loaded. Forward, backward and ping-pong animation streams through the
// tables at one tile per cycle (read of one tile overlapping the write-back
// of the previous). Random animation runs a bit-serial remainder of the
// LFSR value by the range length per tile. A waiting response does not
// block the next command item.
// ----------------------------------------------------------------------------
module tile_animation_index_table_top #(
	parameter int unsigned TILE_COUNT = tai_pkg::TILE_COUNT_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	tai_cmd_if.sink    cmd,
	tai_rsp_if.source  rsp
);
	import tai_pkg::*;

	localparam int              AW        = $clog2(TILE_COUNT);
	localparam int              BW        = $clog2(LFSR_W);
	localparam logic [AW-1:0]   LAST_TILE = AW'(TILE_COUNT - 1);

	state_t state_q, state_d;

	logic [OP_W-1:0]   opcode_q;
	logic [MODE_W-1:0] mode_q;
	logic [AW-1:0]     lo_q, hi_q, addr_q, val_q;
	logic [AW:0]       span_q;
	logic [AW-1:0]     ptr_q;
	logic              ptr_done_q;
	logic [AW-1:0]     clr_q;
	logic              pend_s1;
	logic [AW-1:0]     waddr_s1;
	logic [LFSR_W-1:0] lfsr_q;
	logic [AW-1:0]     rem_q;
	logic [BW-1:0]     bit_q;
	logic [FIELD_W-1:0] res_value_q;
	logic              res_reverse_q;
	logic              out_vld_q;
	logic [FIELD_W-1:0] out_value_q;
	logic              out_reverse_q;

	logic                                cmd_acc;
	logic                                rsp_load;
	logic [WRAP_FIELDS-1:0][FIELD_W-1:0] wrap_in;
	logic [WRAP_FIELDS-1:0][AW-1:0]      wrap_out;
	logic                                wrap_vld;
	logic                                rng_ok;

	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic          tile_we;
	logic [AW-1:0] tile_waddr, tile_wdata, tile_rdata;
	logic          flag_we;
	logic [AW-1:0] flag_waddr;
	logic          flag_wdata, flag_rdata;

	logic [AW-1:0] tile_up, tile_dn, adv_value;
	logic          adv_flag;
	logic [AW:0]   trial;
	logic [AW-1:0] rem_next;

	assign cmd_acc  = cmd.valid && cmd.ready;
	assign rsp_load = (state_q == ST_RESP) && (!out_vld_q || rsp.ready);

	// Field reduction
	assign wrap_in[F_FIRST] = cmd.first_tile;
	assign wrap_in[F_LAST]  = cmd.last_tile;
	assign wrap_in[F_ENTRY] = cmd.entry;
	assign wrap_in[F_VALUE] = cmd.entry_value;

	tai_wrap #(
		.TILE_COUNT (TILE_COUNT),
		.AW         (AW)
	) u_wrap (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (cmd_acc),
		.in_fields  (wrap_in),
		.out_valid  (wrap_vld),
		.out_fields (wrap_out)
	);

	assign rng_ok = wrap_out[F_FIRST] <= wrap_out[F_LAST];

	// Tables
	tai_ram #(
		.WIDTH (AW),
		.DEPTH (TILE_COUNT)
	) u_tile_ram (
		.clk     (clk),
		.wr_en   (tile_we),
		.wr_addr (tile_waddr),
		.wr_data (tile_wdata),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (tile_rdata)
	);

	tai_ram #(
		.WIDTH (1),
		.DEPTH (TILE_COUNT)
	) u_flag_ram (
		.clk     (clk),
		.wr_en   (flag_we),
		.wr_addr (flag_waddr),
		.wr_data (flag_wdata),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (flag_rdata)
	);

	// Per-tile advance from the value just read
	always_comb begin
		tile_up   = (tile_rdata == LAST_TILE) ? '0 : tile_rdata + 1'b1;
		tile_dn   = (tile_rdata == '0) ? LAST_TILE : tile_rdata - 1'b1;
		adv_value = tile_rdata;
		adv_flag  = flag_rdata;
		case (mode_q)
			MODE_FWD: begin
				adv_value = (tile_rdata < hi_q) ? tile_up : lo_q;
			end
			MODE_BWD: begin
				adv_value = (tile_rdata > lo_q) ? tile_dn : hi_q;
			end
			MODE_PING: begin
				if (flag_rdata) begin
					if (tile_rdata != lo_q) begin
						adv_value = tile_dn;
					end else begin
						adv_value = tile_up;
						adv_flag  = 1'b0;
					end
				end else begin
					if (tile_rdata != hi_q) begin
						adv_value = tile_up;
					end else begin
						adv_value = tile_dn;
						adv_flag  = 1'b1;
					end
				end
			end
			default: begin
				adv_value = tile_rdata;
			end
		endcase
	end

	// Bit-serial remainder of the LFSR value by the range length
	always_comb begin
		trial = {rem_q, lfsr_q[bit_q]};
		if (trial >= span_q) begin
			rem_next = AW'(trial - span_q);
		end else begin
			rem_next = trial[AW-1:0];
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == LAST_TILE) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (cmd.valid) begin
					state_d = ST_WRAP;
				end
			end
			ST_WRAP: begin
				if (wrap_vld) begin
					case (opcode_q)
						OP_ANIMATE: begin
							if (!rng_ok) begin
								state_d = ST_RESP;
							end else if (mode_q == MODE_RAND) begin
								state_d = ST_RAND_STEP;
							end else begin
								state_d = ST_ANIM;
							end
						end
						OP_READ:  state_d = ST_READ;
						OP_WRITE: state_d = ST_WRITE;
						default:  state_d = ST_RESP;
					endcase
				end
			end
			ST_ANIM: begin
				if (ptr_done_q && !pend_s1) begin
					state_d = ST_RESP;
				end
			end
			ST_RAND_STEP: state_d = ST_RAND_DIV;
			ST_RAND_DIV: begin
				if (bit_q == '0) begin
					state_d = ST_RAND_WR;
				end
			end
			ST_RAND_WR: begin
				state_d = (ptr_q == hi_q) ? ST_RESP : ST_RAND_STEP;
			end
			ST_READ:  state_d = ST_RDATA;
			ST_RDATA: state_d = ST_RESP;
			ST_WRITE: state_d = ST_RESP;
			ST_RESP: begin
				if (rsp_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Table access and handshake outputs
	always_comb begin
		cmd.ready  = (state_q == ST_IDLE);
		rd_en      = 1'b0;
		rd_addr    = ptr_q;
		tile_we    = 1'b0;
		tile_waddr = waddr_s1;
		tile_wdata = adv_value;
		flag_we    = 1'b0;
		flag_waddr = waddr_s1;
		flag_wdata = adv_flag;
		case (state_q)
			ST_CLEAR: begin
				tile_we    = 1'b1;
				tile_waddr = clr_q;
				tile_wdata = clr_q;
				flag_we    = 1'b1;
				flag_waddr = clr_q;
				flag_wdata = 1'b0;
			end
			ST_ANIM: begin
				// Read the next tile while writing back the previous one
				rd_en   = !ptr_done_q;
				tile_we = pend_s1;
				flag_we = pend_s1 && (mode_q == MODE_PING);
			end
			ST_RAND_WR: begin
				tile_we    = 1'b1;
				tile_waddr = ptr_q;
				tile_wdata = lo_q + rem_q;
			end
			ST_READ: begin
				rd_en   = 1'b1;
				rd_addr = addr_q;
			end
			ST_WRITE: begin
				tile_we    = 1'b1;
				tile_waddr = addr_q;
				tile_wdata = val_q;
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	assign rsp.valid        = out_vld_q;
	assign rsp.read_value   = out_value_q;
	assign rsp.read_reverse = out_reverse_q;

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_q      <= '0;
			lfsr_q     <= LFSR_SEED;
			pend_s1    <= 1'b0;
			ptr_done_q <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (state_q == ST_RAND_STEP) begin
				lfsr_q <= lfsr_next(lfsr_q);
			end
			pend_s1 <= (state_q == ST_ANIM) && !ptr_done_q;
			if (state_q == ST_WRAP) begin
				ptr_done_q <= 1'b0;
			end else if (state_q == ST_ANIM && !ptr_done_q && ptr_q == hi_q) begin
				ptr_done_q <= 1'b1;
			end
			if (rsp_load) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (cmd_acc) begin
			opcode_q <= cmd.opcode;
			mode_q   <= cmd.anim_mode;
		end
		case (state_q)
			ST_WRAP: begin
				lo_q          <= wrap_out[F_FIRST];
				hi_q          <= wrap_out[F_LAST];
				addr_q        <= wrap_out[F_ENTRY];
				val_q         <= wrap_out[F_VALUE];
				span_q        <= {1'b0, wrap_out[F_LAST]} - {1'b0, wrap_out[F_FIRST]} + 1'b1;
				ptr_q         <= wrap_out[F_FIRST];
				res_value_q   <= '0;
				res_reverse_q <= 1'b0;
			end
			ST_ANIM: begin
				waddr_s1 <= ptr_q;
				if (!ptr_done_q && ptr_q != hi_q) begin
					ptr_q <= ptr_q + 1'b1;
				end
			end
			ST_RAND_STEP: begin
				rem_q <= '0;
				bit_q <= BW'(LFSR_W - 1);
			end
			ST_RAND_DIV: begin
				rem_q <= rem_next;
				bit_q <= bit_q - 1'b1;
			end
			ST_RAND_WR: begin
				ptr_q <= ptr_q + 1'b1;
			end
			ST_RDATA: begin
				res_value_q   <= FIELD_W'(tile_rdata);
				res_reverse_q <= flag_rdata;
			end
			default: begin
				waddr_s1 <= waddr_s1;
			end
		endcase
		if (rsp_load) begin
			out_value_q   <= res_value_q;
			out_reverse_q <= res_reverse_q;
		end
	end

endmodule
